### hw/rtl/ttl_pkg.sv
// Package for the throttle thrust limiter: field widths, register reset
// values, codes and the request/result payload structs. No dependencies.
package ttl_pkg;

  // Field widths
  localparam int LEVEL_BITS   = 15;
  localparam int SECONDS_BITS = 16;
  localparam int FACTOR_BITS  = 9;
  localparam int NOW_BITS     = 32;
  localparam int CMD_BITS     = 7;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  // Default width of the time base.
  localparam int TIME_BITS_DEF = 32;

  // Register reset values
  localparam logic [LEVEL_BITS-1:0]   LIMIT_RESET    = 15'd25600;
  localparam logic [SECONDS_BITS-1:0] HOLD_RESET     = 16'd0;
  localparam logic [SECONDS_BITS-1:0] COOLDOWN_RESET = 16'd0;
  localparam logic [FACTOR_BITS-1:0]  FACTOR_RESET   = 9'd256;

  // Full weight of the smoother and the command ceiling
  localparam logic [FACTOR_BITS-1:0] FACTOR_FULL = 9'd256;
  localparam logic [CMD_BITS-1:0]    CMD_MAX     = 7'd100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LIMIT_LEVEL      = 2'd0,
    CFG_HOLD_SECONDS     = 2'd1,
    CFG_COOLDOWN_SECONDS = 2'd2,
    CFG_SMOOTHING_FACTOR = 2'd3
  } ttl_cfg_idx_t;

  // Request operations
  typedef enum logic [0:0] {
    OP_UPDATE = 1'b0,
    OP_PRIME  = 1'b1
  } ttl_op_t;

  // Limiter modes
  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_EXCEEDED = 2'd1,
    MODE_LOCKED   = 2'd2,
    MODE_COOLDOWN = 2'd3
  } ttl_mode_t;

  // Request payload
  typedef struct packed {
    ttl_op_t               operation;
    logic [LEVEL_BITS-1:0] demand;
    logic [NOW_BITS-1:0]   now_seconds;
  } ttl_in_t;

  // Result payload
  typedef struct packed {
    logic [CMD_BITS-1:0] motor_command;
    ttl_mode_t           limit_state;
  } ttl_out_t;

endpackage

### hw/rtl/ttl_stream_if.sv
// Valid/ready stream channel carrying one payload of a given type.
// Used with the payload structs of ttl_pkg.
interface ttl_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### hw/rtl/throttle_thrust_limiter_core.sv
// Throttle thrust limiter with lock/cooldown state and command smoothing.
// Depends on ttl_pkg and ttl_stream_if.
// An update request passes through the input register and then the result register.
// Throughput: one request per cycle unless a pending result is not taken; the
// state updates in the compute stage, so back-to-back requests see the previous one's state.
// A prime request loads the smoother and gives no result.
// Reset (rst_n low, synchronous): registers to their defaults, mode normal,
// timestamp and smoothed level zero, both pipeline stages empty.
module throttle_thrust_limiter_core #(
  parameter int TIME_BITS = ttl_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ttl_stream_if.sink                           in_chan,
  ttl_stream_if.source                         out_chan,
  input  logic                                 cfg_we,
  input  logic [ttl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ttl_pkg::CFG_BITS-1:0]         cfg_wdata
);

  import ttl_pkg::*;

  // Configuration registers
  logic [LEVEL_BITS-1:0]   limit_level_r;
  logic [SECONDS_BITS-1:0] hold_seconds_r;
  logic [SECONDS_BITS-1:0] cooldown_seconds_r;
  logic [FACTOR_BITS-1:0]  smoothing_factor_r;

  // Limiter state
  ttl_mode_t              mode_r, mode_nxt;
  logic [TIME_BITS-1:0]   stamp_r;
  logic                   stamp_load;
  logic [LEVEL_BITS-1:0]  level_r, level_nxt;

  // Pipeline registers
  logic     s1_valid_r;
  ttl_in_t  s1_item_r;
  logic     out_valid_r, out_valid_nxt;
  ttl_out_t out_item_r;

  // Datapath signals
  logic                  out_free;
  logic                  s1_go;
  logic                  s1_update;
  logic [TIME_BITS-1:0]  now_w;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  over;
  logic                  clamp;
  logic [LEVEL_BITS-1:0] value;
  logic [FACTOR_BITS-1:0] weight;
  logic signed [LEVEL_BITS:0]     diff;
  logic signed [FACTOR_BITS:0]    weight_s;
  logic signed [LEVEL_BITS+FACTOR_BITS+1:0] prod;
  logic signed [LEVEL_BITS+FACTOR_BITS+2:0] acc;
  logic [LEVEL_BITS-1:0] smooth_new;
  logic [LEVEL_BITS:0]   cmd_sum;
  logic [LEVEL_BITS-8:0] cmd_raw;
  logic [CMD_BITS-1:0]   cmd;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_level_r      <= LIMIT_RESET;
      hold_seconds_r     <= HOLD_RESET;
      cooldown_seconds_r <= COOLDOWN_RESET;
      smoothing_factor_r <= FACTOR_RESET;
    end else if (cfg_we) begin
      unique case (ttl_cfg_idx_t'(cfg_index))
        CFG_LIMIT_LEVEL:      limit_level_r      <= cfg_wdata[LEVEL_BITS-1:0];
        CFG_HOLD_SECONDS:     hold_seconds_r     <= cfg_wdata[SECONDS_BITS-1:0];
        CFG_COOLDOWN_SECONDS: cooldown_seconds_r <= cfg_wdata[SECONDS_BITS-1:0];
        CFG_SMOOTHING_FACTOR: smoothing_factor_r <= cfg_wdata[FACTOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: a prime leaves the compute stage without needing the output.
  assign out_free       = !out_valid_r || out_chan.ready;
  assign s1_update      = (s1_item_r.operation == OP_UPDATE);
  assign s1_go          = s1_valid_r && (!s1_update || out_free);
  assign in_chan.ready  = !s1_valid_r || s1_go;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_item_r <= in_chan.payload;
    end
  end

  // Time base and elapsed time since entering the exceeded or cooldown mode
  assign now_w   = TIME_BITS'(s1_item_r.now_seconds);
  assign elapsed = now_w - stamp_r;
  assign over    = s1_item_r.demand > limit_level_r;

  // Mode transitions
  always_comb begin
    mode_nxt   = mode_r;
    stamp_load = 1'b0;
    unique case (mode_r)
      MODE_NORMAL: begin
        if (over) begin
          mode_nxt   = MODE_EXCEEDED;
          stamp_load = 1'b1;
        end
      end
      MODE_EXCEEDED: begin
        if (over && (hold_seconds_r != '0) &&
            (elapsed > TIME_BITS'(hold_seconds_r))) begin
          mode_nxt = MODE_LOCKED;
        end
      end
      MODE_LOCKED: begin
        // After the clamp the value is never above the limit.
        mode_nxt   = MODE_COOLDOWN;
        stamp_load = 1'b1;
      end
      MODE_COOLDOWN: begin
        if (elapsed > TIME_BITS'(cooldown_seconds_r)) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: ;
    endcase
  end

  // Clamp output of the mode logic
  always_comb begin
    clamp = 1'b0;
    unique case (mode_r) inside
      MODE_LOCKED, MODE_COOLDOWN: clamp = over;
      default:                    clamp = 1'b0;
    endcase
  end

  assign value = clamp ? limit_level_r : s1_item_r.demand;

  // Smoother: level + (value - level) * w, rounded half up.
  assign weight   = (smoothing_factor_r > FACTOR_FULL) ? FACTOR_FULL : smoothing_factor_r;
  assign diff     = $signed({1'b0, value}) - $signed({1'b0, level_r});
  assign weight_s = $signed({1'b0, weight});
  assign prod     = diff * weight_s;
  assign acc      = $signed({4'b0, level_r, 8'b0}) + (LEVEL_BITS+FACTOR_BITS+3)'(prod)
                    + (LEVEL_BITS+FACTOR_BITS+3)'(128);
  assign smooth_new = acc[LEVEL_BITS+7:8];

  // Percent command, rounded and capped.
  assign cmd_sum = {1'b0, smooth_new} + (LEVEL_BITS+1)'(128);
  assign cmd_raw = cmd_sum[LEVEL_BITS:8];
  assign cmd     = (cmd_raw > 8'(CMD_MAX)) ? CMD_MAX : cmd_raw[CMD_BITS-1:0];

  assign level_nxt = s1_update ? smooth_new : s1_item_r.demand;

  // Limiter state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      stamp_r <= '0;
      level_r <= '0;
    end else if (s1_go) begin
      level_r <= level_nxt;
      if (s1_update) begin
        mode_r <= mode_nxt;
        if (stamp_load) begin
          stamp_r <= now_w;
        end
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_update) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_update) begin
      out_item_r.motor_command <= cmd;
      out_item_r.limit_state   <= mode_nxt;
    end
  end

endmodule
